// ===== rtl/rws_pkg.sv =====
// Shared types and constants for the roulette wheel selection block.
`default_nettype none
package rws_pkg;

    // Fixed field widths
    localparam int IDX_W = 6;
    localparam int FIT_W = 16;
    localparam int RND_W = 31;
    localparam int CNT_W = 7;
    localparam int BIT_W = 5;

    // Operation codes carried by the op field
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    // Reset value of the entries-in-use register
    localparam logic [CNT_W-1:0] ENTRIES_RESET = 7'd64;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_MOD  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/roulette_wheel_select.sv =====
// Top level of the roulette wheel (fitness-proportionate) selection block.
//
// Input channel (in_valid / in_stall): a word with op = write stores fitness_value in
// entry entry_index and completes with no result. A word with op = select
// brings random_value and yields one result word on the output channel.
// Output channel (out_valid / out_stall): chosen_index and empty_wheel, held until taken.
// Configuration: cfg_we with cfg_wdata sets the number of entries in use (reset 64).
// A select runs through a small sequencer around one weight-table read port and one
// shared adder: a summing pass, a 31-step restoring modulo, a scan pass and a result
// state in which the result word waits until taken; the block then returns to idle
// and can take the next word. With an empty wheel the modulo and scan passes are
// skipped. The block takes one word at a time; in_stall is high from a select until
// its result has been taken, so a stalled receiver holds the whole block. Reset clears
// the weight table through per-entry valid bits at once, sets entries in use to 64 and
// leaves the block idle with no result pending.
`default_nettype none
module roulette_wheel_select #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        op,
    input  wire logic [rws_pkg::IDX_W-1:0]   entry_index,
    input  wire logic [rws_pkg::FIT_W-1:0]   fitness_value,
    input  wire logic [rws_pkg::RND_W-1:0]   random_value,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [rws_pkg::IDX_W-1:0]        chosen_index,
    output logic                             empty_wheel,
    input  wire logic                        cfg_we,
    input  wire logic [rws_pkg::CNT_W-1:0]   cfg_wdata
);

    // Only entries reachable by entry_index are ever non-zero
    localparam int TABLE_DEPTH = (MAX_ENTRIES < (2 ** rws_pkg::IDX_W)) ?
                                 MAX_ENTRIES : (2 ** rws_pkg::IDX_W);
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int SUM_W = rws_pkg::FIT_W + $clog2(TABLE_DEPTH + 1);
    localparam logic [rws_pkg::CNT_W-1:0] DEPTH_C = rws_pkg::CNT_W'(TABLE_DEPTH);
    localparam logic [rws_pkg::BIT_W-1:0] LAST_BIT = rws_pkg::BIT_W'(rws_pkg::RND_W - 1);

    // Weight memory and per-entry valid bits
    logic [rws_pkg::FIT_W-1:0] mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    valid_reg;
    logic [rws_pkg::FIT_W-1:0] rdata_reg;
    logic                      rvalid_reg;
    logic [AW-1:0]             rd_idx_reg;

    rws_pkg::state_t           state_reg, state_next;
    logic [rws_pkg::CNT_W-1:0] cfg_reg;
    logic [rws_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [rws_pkg::CNT_W-1:0] n_reg, n_next;
    logic                      issued_reg, issued_next;
    logic [SUM_W-1:0]          total_reg, total_next;
    logic [SUM_W-1:0]          rem_reg, rem_next;
    logic [SUM_W-1:0]          running_reg, running_next;
    logic [rws_pkg::RND_W-1:0] rnd_reg, rnd_next;
    logic [rws_pkg::BIT_W-1:0] bit_reg, bit_next;
    logic [rws_pkg::IDX_W-1:0] chosen_reg, chosen_next;
    logic                      empty_reg, empty_next;

    logic                      accept;
    logic                      wr_en;
    logic [AW-1:0]             rd_addr;
    logic [SUM_W-1:0]          word;
    logic [SUM_W-1:0]          acc_sum;
    logic [SUM_W:0]            rem_shift;
    logic                      more;
    logic [rws_pkg::CNT_W-1:0] n_limit;

    assign accept   = in_valid && !in_stall;
    assign wr_en    = accept && (op == rws_pkg::OP_WRITE) &&
                      ({1'b0, entry_index} < DEPTH_C);
    assign rd_addr  = cnt_reg[AW-1:0];
    assign word     = rvalid_reg ? SUM_W'(rdata_reg) : '0;
    assign more     = cnt_reg < n_reg;
    assign n_limit  = (cfg_reg > DEPTH_C) ? DEPTH_C : cfg_reg;

    // Shared adder serves both the summing and the scan pass
    assign acc_sum   = (state_reg == rws_pkg::ST_SUM) ? total_reg + word : running_reg + word;
    assign rem_shift = {rem_reg, rnd_reg[rws_pkg::RND_W-1]};

    // Write and read the weight memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[entry_index[AW-1:0]] <= fitness_value;
        end
        rdata_reg  <= mem[rd_addr];
        rd_idx_reg <= rd_addr;
    end

    // Clear valid bits at reset, mark entries as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[entry_index[AW-1:0]] <= 1'b1;
            end
            rvalid_reg <= valid_reg[rd_addr];
        end
    end

    // Hold the entries-in-use register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rws_pkg::ENTRIES_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        issued_next  = 1'b0;
        total_next   = total_reg;
        rem_next     = rem_reg;
        running_next = running_reg;
        rnd_next     = rnd_reg;
        bit_next     = bit_reg;
        chosen_next  = chosen_reg;
        empty_next   = empty_reg;
        unique case (state_reg)
            rws_pkg::ST_IDLE:
            begin
                if (accept && (op == rws_pkg::OP_SELECT))
                begin
                    state_next = rws_pkg::ST_SUM;
                    cnt_next   = '0;
                    n_next     = n_limit;
                    total_next = '0;
                    rnd_next   = random_value;
                end
            end
            rws_pkg::ST_SUM:
            begin
                // Issue one read a cycle, add each word as it returns
                if (more)
                begin
                    issued_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (issued_reg)
                begin
                    total_next = acc_sum;
                end
                if (!more && !issued_reg)
                begin
                    if (total_reg == '0)
                    begin
                        empty_next  = 1'b1;
                        chosen_next = '0;
                        state_next  = rws_pkg::ST_DONE;
                    end
                    else
                    begin
                        rem_next   = '0;
                        bit_next   = '0;
                        state_next = rws_pkg::ST_MOD;
                    end
                end
            end
            rws_pkg::ST_MOD:
            begin
                // One restoring step per cycle, most significant bit first
                if (rem_shift >= {1'b0, total_reg})
                begin
                    rem_next = SUM_W'(rem_shift - {1'b0, total_reg});
                end
                else
                begin
                    rem_next = rem_shift[SUM_W-1:0];
                end
                rnd_next = {rnd_reg[rws_pkg::RND_W-2:0], 1'b0};
                bit_next = bit_reg + 1'b1;
                if (bit_reg == LAST_BIT)
                begin
                    cnt_next     = '0;
                    running_next = '0;
                    state_next   = rws_pkg::ST_SCAN;
                end
            end
            rws_pkg::ST_SCAN:
            begin
                // Walk the running sum until it passes the reduced value
                if (more)
                begin
                    issued_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (issued_reg)
                begin
                    running_next = acc_sum;
                    if (acc_sum > rem_reg)
                    begin
                        issued_next = 1'b0;
                        chosen_next = rws_pkg::IDX_W'(rd_idx_reg);
                        empty_next  = 1'b0;
                        state_next  = rws_pkg::ST_DONE;
                    end
                end
                else if (!more)
                begin
                    chosen_next = '0;
                    empty_next  = 1'b0;
                    state_next  = rws_pkg::ST_DONE;
                end
            end
            rws_pkg::ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = rws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rws_pkg::ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rws_pkg::ST_IDLE;
            issued_reg <= 1'b0;
            cnt_reg    <= '0;
            n_reg      <= '0;
            bit_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            bit_reg    <= bit_next;
        end
    end

    // Advance datapath registers
    always_ff @(posedge clk)
    begin
        total_reg   <= total_next;
        rem_reg     <= rem_next;
        running_reg <= running_next;
        rnd_reg     <= rnd_next;
        chosen_reg  <= chosen_next;
        empty_reg   <= empty_next;
    end

    assign in_stall     = (state_reg != rws_pkg::ST_IDLE);
    assign out_valid    = (state_reg == rws_pkg::ST_DONE);
    assign chosen_index = chosen_reg;
    assign empty_wheel  = empty_reg;

endmodule
`default_nettype wire

// ===== rtl/rws_checker.sv =====
// Port-level assertions for the roulette wheel selection block and their bind.
`default_nettype none
module rws_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        op,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [rws_pkg::IDX_W-1:0]   chosen_index,
    input wire logic                        empty_wheel
);

    // A waiting result word holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chosen_index) && $stable(empty_wheel))
        else $error("result word changed while stalled");

    // No new word is taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

    // A select keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == rws_pkg::OP_SELECT) |=> in_stall)
        else $error("select did not start the sequencer");

    // A write produces no result word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == rws_pkg::OP_WRITE) |=> !out_valid && !in_stall)
        else $error("write produced a result or stalled");

    // An empty wheel always reports entry zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_wheel |-> (chosen_index == '0))
        else $error("empty wheel with non-zero index");

endmodule

bind roulette_wheel_select rws_checker u_rws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_index (chosen_index),
    .empty_wheel  (empty_wheel)
);
`default_nettype wire
